// File: design/lwts_pkg.sv
// ---------------------------------------------------------------------------
// lwts_pkg
// Shared types and constants for the LRU write-back tag store.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lwts_pkg;

  // Default geometry
  localparam int ENTRIES_DEF    = 16;
  localparam int INDEX_BITS_DEF = 16;

  // Fixed field widths
  localparam int CAP_W   = 5;
  localparam int BLOCK_W = 16;
  localparam int COUNT_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Request action codes
  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_ADD   = 2'd2
  } action_t;

  // Controller sequencing
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DECIDE,
    ST_UPDATE
  } state_t;

  // Request payload
  typedef struct packed {
    logic [1:0]         action;
    logic [BLOCK_W-1:0] block_index;
  } req_t;

  // Result payload
  typedef struct packed {
    logic               hit;
    logic               evicted;
    logic [BLOCK_W-1:0] victim_index;
    logic               victim_dirty;
    logic [COUNT_W-1:0] hit_total;
    logic [COUNT_W-1:0] access_total;
  } rsp_t;

  // Per-request outcome from the controller to the top level
  typedef struct packed {
    logic               valid;
    logic               lookup;
    logic               hit;
    logic               evicted;
    logic [BLOCK_W-1:0] victim_index;
    logic               victim_dirty;
  } outcome_t;

endpackage

// File: design/lwts_ram.sv
// ---------------------------------------------------------------------------
// lwts_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lwts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/lwts_ctrl.sv
// ---------------------------------------------------------------------------
// lwts_ctrl
// Entry RAM plus sequencer: a search sweep over all entries, then for an update
// a read-modify-write sweep that rewrites recency ranks and the target entry.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lwts_ctrl #(
  parameter int ENTRIES    = lwts_pkg::ENTRIES_DEF,
  parameter int INDEX_BITS = lwts_pkg::INDEX_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  lwts_pkg::req_t               req,
  input  logic [$clog2(ENTRIES+1)-1:0] cap_eff,
  output logic                         busy,
  output lwts_pkg::outcome_t           res
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int WORD_W = INDEX_BITS + 1 + IDX_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  lwts_pkg::state_t state, state_next;

  // Sweep pointer and read-data tracking
  logic [CNT_W-1:0]      ptr;
  logic                  chk;
  logic [IDX_W-1:0]      chk_idx;
  logic                  issue;
  logic                  sweep_end;

  logic [ENTRIES-1:0]    entry_valid;

  // Captured request
  logic [INDEX_BITS-1:0] req_tag;
  logic [1:0]            req_action;

  // Search results
  logic [CNT_W-1:0]      held;
  logic                  match_found;
  logic [IDX_W-1:0]      match_idx;
  logic [IDX_W-1:0]      match_rank;
  logic                  match_dirty;
  logic                  free_found;
  logic [IDX_W-1:0]      free_idx;
  logic                  vic_found;
  logic [IDX_W-1:0]      vic_idx;
  logic [IDX_W-1:0]      vic_rank;
  logic [INDEX_BITS-1:0] vic_tag;
  logic                  vic_dirty;

  // Update plan
  logic [IDX_W-1:0]      tgt_idx;
  logic [IDX_W-1:0]      old_rank;
  logic                  age_all;
  logic                  new_dirty;

  logic                  plan_update;
  logic                  plan_fill;
  logic                  plan_evict;
  logic [IDX_W-1:0]      plan_tgt;
  logic [IDX_W-1:0]      plan_old;
  logic                  plan_age_all;
  logic                  plan_dirty;
  logic                  res_lookup;
  logic                  res_hit;

  // RAM ports; word = {tag, dirty, rank}
  logic                  wr_en;
  logic [WORD_W-1:0]     wr_data;
  logic [WORD_W-1:0]     rd_word;
  logic [INDEX_BITS-1:0] e_tag;
  logic                  e_dirty;
  logic [IDX_W-1:0]      e_rank;
  logic                  e_valid;

  lwts_ram #(
    .WIDTH(WORD_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(chk_idx),
    .wr_data(wr_data),
    .rd_en  (issue),
    .rd_addr(ptr[IDX_W-1:0]),
    .rd_data(rd_word)
  );

  assign e_tag   = rd_word[WORD_W-1 -: INDEX_BITS];
  assign e_dirty = rd_word[IDX_W];
  assign e_rank  = rd_word[IDX_W-1:0];
  assign e_valid = entry_valid[chk_idx];

  assign issue = (state == lwts_pkg::ST_SEARCH || state == lwts_pkg::ST_UPDATE) &&
                 (ptr < CNT_W'(ENTRIES));
  assign sweep_end = chk && (chk_idx == LAST);

  // Decision from the search results
  always_comb begin
    plan_update  = 1'b0;
    plan_fill    = 1'b0;
    plan_evict   = 1'b0;
    plan_tgt     = match_idx;
    plan_old     = match_rank;
    plan_age_all = 1'b0;
    plan_dirty   = match_dirty;
    res_lookup   = 1'b0;
    res_hit      = 1'b0;
    unique case (req_action)
      lwts_pkg::ACT_READ: begin
        res_lookup  = 1'b1;
        res_hit     = match_found;
        plan_update = match_found;
      end
      lwts_pkg::ACT_WRITE: begin
        res_lookup  = 1'b1;
        res_hit     = match_found;
        plan_update = match_found;
        plan_dirty  = 1'b1;
      end
      lwts_pkg::ACT_ADD: begin
        plan_update = 1'b1;
        if (match_found) begin
          res_hit = 1'b1;
        end else if (held < cap_eff) begin
          // fill the lowest free entry, every held entry ages
          plan_fill    = 1'b1;
          plan_tgt     = free_idx;
          plan_old     = '0;
          plan_age_all = 1'b1;
          plan_dirty   = 1'b0;
        end else begin
          // replace the least recent entry
          plan_evict = 1'b1;
          plan_tgt   = vic_idx;
          plan_old   = vic_rank;
          plan_dirty = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Outcome, presented for the single decide cycle
  always_comb begin
    res              = '0;
    res.valid        = (state == lwts_pkg::ST_DECIDE);
    res.lookup       = res_lookup;
    res.hit          = res_hit;
    res.evicted      = plan_evict;
    res.victim_index = plan_evict ? lwts_pkg::BLOCK_W'(vic_tag) : '0;
    res.victim_dirty = plan_evict & vic_dirty;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      lwts_pkg::ST_IDLE:   if (start) state_next = lwts_pkg::ST_SEARCH;
      lwts_pkg::ST_SEARCH: if (sweep_end) state_next = lwts_pkg::ST_DECIDE;
      lwts_pkg::ST_DECIDE: begin
        state_next = plan_update ? lwts_pkg::ST_UPDATE : lwts_pkg::ST_IDLE;
      end
      lwts_pkg::ST_UPDATE: if (sweep_end) state_next = lwts_pkg::ST_IDLE;
      default:             state_next = lwts_pkg::ST_IDLE;
    endcase
  end

  assign busy = (state != lwts_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lwts_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Write-back of the entry read in the previous cycle
  always_comb begin
    wr_en   = 1'b0;
    wr_data = rd_word;
    if (state == lwts_pkg::ST_UPDATE && chk) begin
      if (chk_idx == tgt_idx) begin
        wr_en   = 1'b1;
        wr_data = {req_tag, new_dirty, IDX_W'(0)};
      end else if (e_valid && (age_all || e_rank < old_rank)) begin
        wr_en   = 1'b1;
        wr_data = {e_tag, e_dirty, e_rank + IDX_W'(1)};
      end
    end
  end

  // Sweep pointer, search bookkeeping and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr         <= '0;
      chk         <= 1'b0;
      entry_valid <= '0;
    end else begin
      chk     <= issue;
      chk_idx <= ptr[IDX_W-1:0];

      if (state == lwts_pkg::ST_IDLE || state == lwts_pkg::ST_DECIDE) begin
        ptr <= '0;
      end else if (issue) begin
        ptr <= ptr + CNT_W'(1);
      end

      if (state == lwts_pkg::ST_IDLE && start) begin
        req_tag     <= INDEX_BITS'(req.block_index);
        req_action  <= req.action;
        held        <= '0;
        match_found <= 1'b0;
        free_found  <= 1'b0;
        vic_found   <= 1'b0;
      end

      // one entry examined per cycle
      if (state == lwts_pkg::ST_SEARCH && chk) begin
        held <= held + CNT_W'(e_valid);
        if (e_valid && e_tag == req_tag && !match_found) begin
          match_found <= 1'b1;
          match_idx   <= chk_idx;
          match_rank  <= e_rank;
          match_dirty <= e_dirty;
        end
        if (!e_valid && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= chk_idx;
        end
        if (e_valid && (!vic_found || e_rank > vic_rank)) begin
          vic_found <= 1'b1;
          vic_idx   <= chk_idx;
          vic_rank  <= e_rank;
          vic_tag   <= e_tag;
          vic_dirty <= e_dirty;
        end
      end

      if (state == lwts_pkg::ST_DECIDE) begin
        tgt_idx   <= plan_tgt;
        old_rank  <= plan_old;
        age_all   <= plan_age_all;
        new_dirty <= plan_dirty;
        if (plan_fill) begin
          entry_valid[free_idx] <= 1'b1;
        end
      end
    end
  end

  // Checks
  a_outcome_after_search: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> $past(state) == lwts_pkg::ST_SEARCH)
    else $error("outcome without a completed search");

  a_fill_has_free: assert property (@(posedge clk) disable iff (rst)
    (state == lwts_pkg::ST_DECIDE && plan_fill) |-> free_found)
    else $error("fill chosen with no free entry");

  a_evict_has_victim: assert property (@(posedge clk) disable iff (rst)
    (state == lwts_pkg::ST_DECIDE && plan_evict) |-> vic_found)
    else $error("eviction chosen with no victim");

  a_valid_grows: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> $countones(entry_valid) >= $past($countones(entry_valid)))
    else $error("entry lost its valid mark");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (wr_en && issue) |-> chk_idx != ptr[IDX_W-1:0])
    else $error("write and read to the same entry in one cycle");

endmodule

// File: design/lru_writeback_tag_store.sv
// ---------------------------------------------------------------------------
// lru_writeback_tag_store
// Fully associative tag store with LRU replacement and dirty marks.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel: a request (action, block_index) is taken at a clock edge
//   with start high and busy low. Actions: read lookup, write lookup (marks
//   the entry dirty), add. Unused action codes change nothing.
//   Result channel: done is high for exactly one cycle with rsp holding hit,
//   evicted, victim_index, victim_dirty and the running hit/access totals.
//   The receiver cannot stall; each result is shown once.
//   Configuration: cfg_wr_en writes the capacity register from cfg_wr_data;
//   write it only while busy is low and no result is pending.
// Sequencing:
//   The entry RAM has one read port and is walked one entry per cycle.
//   done rises after a search walk over all entries. A request that
//   changes no entry lets the next one be taken once that walk is done;
//   one that rewrites recency takes a second walk before the next request
//   is taken.
// Reset:
//   rst clears all valid marks, both totals and sets capacity to 16.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_writeback_tag_store #(
  parameter int ENTRIES    = lwts_pkg::ENTRIES_DEF,
  parameter int INDEX_BITS = lwts_pkg::INDEX_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  lwts_pkg::req_t             req,
  input  logic                       cfg_wr_en,
  input  logic [lwts_pkg::CAP_W-1:0] cfg_wr_data,
  output logic                       done,
  output lwts_pkg::rsp_t             rsp
);

  localparam int CNT_W = $clog2(ENTRIES + 1);

  logic [lwts_pkg::CAP_W-1:0]   capacity;
  logic [CNT_W-1:0]             cap_eff;
  logic [lwts_pkg::COUNT_W-1:0] hit_count, hit_count_next;
  logic [lwts_pkg::COUNT_W-1:0] access_count, access_count_next;
  lwts_pkg::outcome_t           res;

  lwts_ctrl #(
    .ENTRIES   (ENTRIES),
    .INDEX_BITS(INDEX_BITS)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .cap_eff(cap_eff),
    .busy   (busy),
    .res    (res)
  );

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lwts_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  // Clamp capacity into 1..ENTRIES
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CNT_W'(1);
    end else if (32'(capacity) > ENTRIES) begin
      cap_eff = CNT_W'(ENTRIES);
    end else begin
      cap_eff = CNT_W'(capacity);
    end
  end

  // Lookup totals
  always_comb begin
    hit_count_next    = hit_count;
    access_count_next = access_count;
    if (res.valid && res.lookup) begin
      access_count_next = access_count + lwts_pkg::COUNT_W'(1);
      if (res.hit) begin
        hit_count_next = hit_count + lwts_pkg::COUNT_W'(1);
      end
    end
  end

  // Counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count    <= '0;
      access_count <= '0;
      done         <= 1'b0;
    end else begin
      hit_count    <= hit_count_next;
      access_count <= access_count_next;
      done         <= res.valid;
      if (res.valid) begin
        rsp.hit          <= res.hit;
        rsp.evicted      <= res.evicted;
        rsp.victim_index <= res.victim_index;
        rsp.victim_dirty <= res.victim_dirty;
        rsp.hit_total    <= hit_count_next;
        rsp.access_total <= access_count_next;
      end
    end
  end

endmodule

// File: tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the LRU write-back tag store. A directed table
// covers empty-store misses, fills, held-index adds, dirty victims, unused
// action codes and capacity changes (including lowering it below the held
// count). Random phases with bursty requests, drawn mostly from a small
// pool of block indices, follow. Each result is checked against hand-written
// expected values or a local shadow of the tag store.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int NUM_ENTRIES      = lwts_pkg::ENTRIES_DEF;
  localparam int CAP_W            = lwts_pkg::CAP_W;
  localparam int BLOCK_W          = lwts_pkg::BLOCK_W;
  localparam int COUNT_W          = lwts_pkg::COUNT_W;
  localparam int SETTLE_CYCLES    = 2 * NUM_ENTRIES + 4;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int PHASES           = 8;
  localparam int ITEMS_PER_PHASE  = 150;
  localparam int POOL_MAX         = 24;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    lwts_pkg::req_t   r;
    logic [CAP_W-1:0] cap;
    bit               typed;
    lwts_pkg::rsp_t   want;
  } stim_row_t;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  lwts_pkg::req_t   req_in;
  logic             cfg_wr_en;
  logic [CAP_W-1:0] cfg_wr_data;
  logic             done;
  lwts_pkg::rsp_t   rsp_out;

  // Shadow of the tag store
  logic [BLOCK_W-1:0] shadow_tag   [NUM_ENTRIES];
  bit                 shadow_valid [NUM_ENTRIES];
  bit                 shadow_dirty [NUM_ENTRIES];
  int unsigned        shadow_rank  [NUM_ENTRIES];
  logic [COUNT_W-1:0] shadow_hits;
  logic [COUNT_W-1:0] shadow_accesses;
  logic [CAP_W-1:0]   shadow_capacity;

  lwts_pkg::rsp_t expected_rsp_q [$];
  stim_row_t      directed_rows  [$];
  int             mismatch_count;
  int             idle_cycles;

  lru_writeback_tag_store u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req         (req_in),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .done        (done),
    .rsp         (rsp_out)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---- predictor ----

  function automatic int find_entry(logic [BLOCK_W-1:0] tag);
    for (int i = 0; i < NUM_ENTRIES; i++)
      if (shadow_valid[i] && shadow_tag[i] == tag) return i;
    return -1;
  endfunction

  // Entry e becomes most recent; other valid entries newer than it age by one, or all of them if e was not held
  function automatic void promote_entry(int e, bit was_held);
    int unsigned old_rank;
    old_rank = shadow_rank[e];
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (i != e && shadow_valid[i] && (!was_held || shadow_rank[i] < old_rank))
        shadow_rank[i]++;
    end
    shadow_rank[e] = 0;
  endfunction

  function automatic lwts_pkg::rsp_t predict_tag_store(lwts_pkg::req_t r);
    lwts_pkg::rsp_t     res;
    int                 e;
    int                 v;
    int                 held;
    int                 cap;
    logic [BLOCK_W-1:0] tag;
    res  = '0;
    tag  = r.block_index;
    cap  = int'(shadow_capacity);
    held = 0;
    if (cap < 1) cap = 1;
    if (cap > NUM_ENTRIES) cap = NUM_ENTRIES;
    case (r.action)
      lwts_pkg::ACT_READ, lwts_pkg::ACT_WRITE: begin
        shadow_accesses++;
        e = find_entry(tag);
        if (e >= 0) begin
          res.hit = 1'b1;
          shadow_hits++;
          promote_entry(e, 1'b1);
          if (r.action == lwts_pkg::ACT_WRITE) shadow_dirty[e] = 1'b1;
        end
      end
      lwts_pkg::ACT_ADD: begin
        e = find_entry(tag);
        if (e >= 0) begin
          // held index: recency refresh only
          res.hit = 1'b1;
          promote_entry(e, 1'b1);
        end else begin
          for (int i = 0; i < NUM_ENTRIES; i++)
            if (shadow_valid[i]) held++;
          e = -1;
          if (held < cap) begin
            for (int i = 0; i < NUM_ENTRIES; i++)
              if (!shadow_valid[i] && e < 0) e = i;
          end
          if (e >= 0) begin
            shadow_valid[e] = 1'b1;
            shadow_tag[e]   = tag;
            shadow_dirty[e] = 1'b0;
            promote_entry(e, 1'b0);
          end else begin
            v = -1;
            for (int i = 0; i < NUM_ENTRIES; i++)
              if (shadow_valid[i] && (v < 0 || shadow_rank[i] > shadow_rank[v])) v = i;
            if (v >= 0) begin
              res.evicted      = 1'b1;
              res.victim_index = shadow_tag[v];
              res.victim_dirty = shadow_dirty[v];
              shadow_tag[v]    = tag;
              shadow_dirty[v]  = 1'b0;
              promote_entry(v, 1'b1);
            end
          end
        end
      end
      default: ;
    endcase
    res.hit_total    = shadow_hits;
    res.access_total = shadow_accesses;
    return res;
  endfunction

  // ---- directed table rows ----

  function automatic stim_row_t req_row(logic [1:0] act, logic [BLOCK_W-1:0] idx);
    stim_row_t row;
    row.kind              = ROW_REQ;
    row.r.action          = act;
    row.r.block_index     = idx;
    row.cap               = '0;
    row.typed             = 1'b0;
    row.want              = '0;
    return row;
  endfunction

  function automatic stim_row_t typed_row(logic [1:0] act, logic [BLOCK_W-1:0] idx,
                                          logic h, logic ev, logic [BLOCK_W-1:0] vi,
                                          logic vd, logic [COUNT_W-1:0] ht,
                                          logic [COUNT_W-1:0] at);
    stim_row_t row;
    row                   = req_row(act, idx);
    row.typed             = 1'b1;
    row.want.hit          = h;
    row.want.evicted      = ev;
    row.want.victim_index = vi;
    row.want.victim_dirty = vd;
    row.want.hit_total    = ht;
    row.want.access_total = at;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(logic [CAP_W-1:0] value);
    stim_row_t row;
    row      = req_row(lwts_pkg::ACT_READ, '0);
    row.kind = ROW_CFG;
    row.cap  = value;
    return row;
  endfunction

  // ---- driving ----

  // Hold the request until it is taken, then record what it should return
  task automatic send_request(lwts_pkg::req_t r, bit typed, lwts_pkg::rsp_t want);
    lwts_pkg::rsp_t predicted;
    @(negedge clk);
    start  <= 1'b1;
    req_in <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = predict_tag_store(r);
    expected_rsp_q.push_back(typed ? want : predicted);
  endtask

  task automatic pause_sender(int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // All results in, block done with its recency walk
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_capacity = value;
  endtask

  // ---- result checking and watchdog ----

  task automatic report_field(string field, logic [COUNT_W-1:0] got,
                              logic [COUNT_W-1:0] want);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch %s: expected %0h, got %0h at %0t", field, want, got, $realtime);
    end
  endtask

  always @(posedge clk) begin : result_check
    lwts_pkg::rsp_t want_rsp;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (done) begin
        if (expected_rsp_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result at %0t: %p", $realtime, rsp_out);
        end else begin
          want_rsp = expected_rsp_q.pop_front();
          report_field("hit", COUNT_W'(rsp_out.hit), COUNT_W'(want_rsp.hit));
          report_field("evicted", COUNT_W'(rsp_out.evicted), COUNT_W'(want_rsp.evicted));
          report_field("victim_index", COUNT_W'(rsp_out.victim_index),
                       COUNT_W'(want_rsp.victim_index));
          report_field("victim_dirty", COUNT_W'(rsp_out.victim_dirty),
                       COUNT_W'(want_rsp.victim_dirty));
          report_field("hit_total", rsp_out.hit_total, want_rsp.hit_total);
          report_field("access_total", rsp_out.access_total, want_rsp.access_total);
        end
      end
      if ((start && !busy) || done) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---- stimulus ----

  initial begin : stimulus
    logic [CAP_W-1:0]   phase_caps [PHASES];
    logic [BLOCK_W-1:0] pool [POOL_MAX];
    lwts_pkg::req_t     r;
    lwts_pkg::rsp_t     none;
    stim_row_t          row;
    int                 gap_max;
    int                 burst_left;
    int                 psize;
    int                 roll;
    int                 cap_eff;

    rst         = 1'b1;
    start       = 1'b0;
    req_in      = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    none        = '0;
    mismatch_count  = 0;
    idle_cycles     = 0;
    shadow_hits     = '0;
    shadow_accesses = '0;
    shadow_capacity = lwts_pkg::CAP_RESET;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      shadow_tag[i]   = '0;
      shadow_valid[i] = 1'b0;
      shadow_dirty[i] = 1'b0;
      shadow_rank[i]  = 0;
    end

    // Directed table: typed rows follow by hand from the rules, the rest go
    // through the shadow store
    directed_rows.push_back(typed_row(lwts_pkg::ACT_READ,  16'h0000, 0, 0, 16'h0000, 0, 0, 1));
    directed_rows.push_back(typed_row(lwts_pkg::ACT_WRITE, 16'hFFFF, 0, 0, 16'h0000, 0, 0, 2));
    directed_rows.push_back(typed_row(lwts_pkg::ACT_ADD,   16'h0000, 0, 0, 16'h0000, 0, 0, 2));
    directed_rows.push_back(typed_row(lwts_pkg::ACT_ADD,   16'hFFFF, 0, 0, 16'h0000, 0, 0, 2));
    directed_rows.push_back(typed_row(lwts_pkg::ACT_READ,  16'h0000, 1, 0, 16'h0000, 0, 1, 3));
    directed_rows.push_back(typed_row(lwts_pkg::ACT_WRITE, 16'hFFFF, 1, 0, 16'h0000, 0, 2, 4));
    directed_rows.push_back(typed_row(lwts_pkg::ACT_ADD,   16'hFFFF, 1, 0, 16'h0000, 0, 2, 4));
    directed_rows.push_back(typed_row(ACT_UNUSED,          16'h5555, 0, 0, 16'h0000, 0, 2, 4));
    directed_rows.push_back(typed_row(ACT_UNUSED,          16'hAAAA, 0, 0, 16'h0000, 0, 2, 4));
    directed_rows.push_back(typed_row(lwts_pkg::ACT_READ,  16'hAAAA, 0, 0, 16'h0000, 0, 2, 5));
    directed_rows.push_back(cfg_row(5'd2));
    directed_rows.push_back(typed_row(lwts_pkg::ACT_READ,  16'h0000, 1, 0, 16'h0000, 0, 3, 6));
    // full store: dirty victim goes out
    directed_rows.push_back(typed_row(lwts_pkg::ACT_ADD,   16'h1234, 0, 1, 16'hFFFF, 1, 3, 6));
    // capacity lowered below the held count
    directed_rows.push_back(cfg_row(5'd1));
    directed_rows.push_back(typed_row(lwts_pkg::ACT_ADD,   16'h4321, 0, 1, 16'h0000, 0, 3, 6));
    directed_rows.push_back(typed_row(lwts_pkg::ACT_ADD,   16'h5678, 0, 1, 16'h1234, 0, 3, 6));
    directed_rows.push_back(req_row(lwts_pkg::ACT_WRITE, 16'h4321));
    directed_rows.push_back(req_row(lwts_pkg::ACT_ADD,   16'h9ABC));
    // zero capacity acts as one
    directed_rows.push_back(cfg_row(5'd0));
    directed_rows.push_back(req_row(lwts_pkg::ACT_ADD,   16'h0F0F));
    directed_rows.push_back(req_row(lwts_pkg::ACT_READ,  16'h9ABC));
    // oversized capacity acts as the entry count
    directed_rows.push_back(cfg_row(5'd31));
    directed_rows.push_back(req_row(lwts_pkg::ACT_ADD,   16'h1111));
    directed_rows.push_back(req_row(lwts_pkg::ACT_ADD,   16'h2222));
    directed_rows.push_back(req_row(lwts_pkg::ACT_WRITE, 16'h1111));
    directed_rows.push_back(req_row(lwts_pkg::ACT_READ,  16'h3333));
    directed_rows.push_back(cfg_row(5'd17));
    directed_rows.push_back(req_row(lwts_pkg::ACT_ADD,   16'h7FFF));
    directed_rows.push_back(req_row(ACT_UNUSED,          16'hFFFF));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) write_capacity(row.cap);
      else send_request(row.r, row.typed, row.want);
    end

    // Random phases, each at its own capacity; extremes first
    phase_caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd17, 5'd8, 5'd4};
    for (int p = 6; p < PHASES; p++) phase_caps[p] = CAP_W'($urandom_range(0, 31));

    for (int p = 0; p < PHASES; p++) begin
      write_capacity(phase_caps[p]);
      cap_eff = (phase_caps[p] == 0) ? 1 :
                (phase_caps[p] > NUM_ENTRIES) ? NUM_ENTRIES : int'(phase_caps[p]);
      psize = cap_eff + int'($urandom_range(1, 8));
      if (psize > POOL_MAX) psize = POOL_MAX;
      for (int k = 0; k < POOL_MAX; k++) pool[k] = BLOCK_W'($urandom);
      if ($urandom_range(0, 1)) pool[0] = 16'h0000;
      if ($urandom_range(0, 1)) pool[1] = 16'hFFFF;
      // first phase runs back to back
      gap_max    = (p == 0) ? 0 : int'($urandom_range(2, 30));
      burst_left = int'($urandom_range(1, 16));

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        roll = int'($urandom_range(0, 99));
        if (roll < 5)       r.action = ACT_UNUSED;
        else if (roll < 40) r.action = lwts_pkg::ACT_ADD;
        else if (roll < 75) r.action = lwts_pkg::ACT_READ;
        else                r.action = lwts_pkg::ACT_WRITE;
        // mostly pool indices so hits and evictions happen; some noise
        if ($urandom_range(0, 9) == 0) r.block_index = BLOCK_W'($urandom);
        else r.block_index = pool[$urandom_range(0, psize - 1)];
        send_request(r, 1'b0, none);

        burst_left--;
        if (burst_left == 0) begin
          if (gap_max > 0) pause_sender(int'($urandom_range(1, gap_max)));
          burst_left = int'($urandom_range(1, 16));
        end
      end

      // after phase 3 the sender holds off until the block has drained once
      if (p == 3) wait_idle();
    end

    wait_idle();
    if (mismatch_count == 0 && expected_rsp_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// File: files.f
design/lwts_pkg.sv
design/lwts_ram.sv
design/lwts_ctrl.sv
design/lru_writeback_tag_store.sv
tb/tb.sv
